// File: design/cspw_pkg.sv
// ----------------------------------------------------------------------------
// cspw_pkg: shared types and codes
// Operation, status and sequencing codes plus the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cspw_pkg;

   // operations
   localparam logic [2:0] OP_CREATE  = 3'd0;
   localparam logic [2:0] OP_WAIT    = 3'd1;
   localparam logic [2:0] OP_TRYWAIT = 3'd2;
   localparam logic [2:0] OP_POST    = 3'd3;
   localparam logic [2:0] OP_GETVAL  = 3'd4;
   localparam logic [2:0] OP_CANCEL  = 3'd5;
   localparam logic [2:0] OP_CLOSE   = 3'd6;
   localparam logic [2:0] OP_DESTROY = 3'd7;

   // reply status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_AGAIN    = 3'd1;
   localparam logic [2:0] ST_NOSPACE  = 3'd2;
   localparam logic [2:0] ST_INVALID  = 3'd3;
   localparam logic [2:0] ST_TOOMANY  = 3'd4;
   localparam logic [2:0] ST_INTR     = 3'd5;
   localparam logic [2:0] ST_BADH     = 3'd6;
   localparam logic [2:0] ST_NOTFOUND = 3'd7;

   // configuration register indexes
   localparam logic CSR_MAX_VALUE = 1'b0;
   localparam logic CSR_MAX_OPEN  = 1'b1;

   // step that follows the load of a semaphore
   localparam logic [2:0] NXT_FINAL = 3'd0;
   localparam logic [2:0] NXT_WALK  = 3'd1;
   localparam logic [2:0] NXT_LINK  = 3'd2;
   localparam logic [2:0] NXT_POST  = 3'd3;
   localparam logic [2:0] NXT_FLUSH = 3'd4;

   typedef struct packed {
      logic capture;
      logic load;
      logic walk;
      logic link;
      logic post;
      logic flush;
      logic fin;
   } cspw_cmd_type;

   typedef struct packed {
      logic [2:0] after_load;
      logic       walk_last;
      logic       walk_insert;
   } cspw_stat_type;

endpackage

// File: design/counting_semaphore_priority_waitq.sv
// A request without a queue walk steps through load and final reply after
// acceptance. Queue walks (wait insertion, cancel, close, destroy) visit
// waiter entries, up to WAITER_SLOTS, then take a link or flush step; a
// post that wakes a waiter adds a handoff step. One request is in flight at a
// time; busy drops in the cycle the final reply shows. Replies are strobed
// for one cycle each. Reset (synchronous) clears live flags and waiter pool.
// ----------------------------------------------------------------------------
// counting_semaphore_priority_waitq: semaphore bank with priority wait queue
// Counting semaphores sharing a pool of priority-ordered waiter entries.
// ----------------------------------------------------------------------------
module counting_semaphore_priority_waitq #(
   parameter int SEM_SLOTS    = 64,
   parameter int WAITER_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [5:0]  req_sem_index,
   input  logic [15:0] req_request_id,
   input  logic [15:0] req_conn_server,
   input  logic [15:0] req_conn_client,
   input  logic [7:0]  req_priority_req,
   input  logic [30:0] req_initial_value,
   output logic        rsp_strobe,
   output logic [15:0] rsp_reply_to,
   output logic [2:0]  rsp_status,
   output logic [30:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [30:0] csr_wdata
);

   cspw_pkg::cspw_cmd_type  cmd;
   cspw_pkg::cspw_stat_type stat;

   cspw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cspw_dp #(.SEM_SLOTS(SEM_SLOTS), .WAITER_SLOTS(WAITER_SLOTS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_sem_index     (req_sem_index),
      .req_request_id    (req_request_id),
      .req_conn_server   (req_conn_server),
      .req_conn_client   (req_conn_client),
      .req_priority_req  (req_priority_req),
      .req_initial_value (req_initial_value),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_reply_to      (rsp_reply_to),
      .rsp_status        (rsp_status),
      .rsp_value         (rsp_value),
      .rsp_last          (rsp_last)
   );

endmodule

// File: design/cspw_ram.sv
// ----------------------------------------------------------------------------
// cspw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cspw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/cspw_ctrl.sv
// ----------------------------------------------------------------------------
// cspw_ctrl: request sequencer
// Steps each request through load, queue walk, link, handoff, flush and
// final reply, driven by status from the datapath.
// ----------------------------------------------------------------------------
module cspw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  cspw_pkg::cspw_stat_type stat,
   output cspw_pkg::cspw_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_LINK  = 3'd3;
   localparam logic [2:0] S_POST  = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;
   localparam logic [2:0] S_FINAL = 3'd6;

   logic [2:0] state_ff, state_in;

   // pick the next step
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_LOAD;
         end
         S_LOAD: begin
            case (stat.after_load)
               cspw_pkg::NXT_WALK:  state_in = S_WALK;
               cspw_pkg::NXT_LINK:  state_in = S_LINK;
               cspw_pkg::NXT_POST:  state_in = S_POST;
               cspw_pkg::NXT_FLUSH: state_in = S_FLUSH;
               default:             state_in = S_FINAL;
            endcase
         end
         S_WALK: begin
            if (stat.walk_last) state_in = stat.walk_insert ? S_LINK : S_FLUSH;
         end
         S_LINK:  state_in = S_FINAL;
         S_POST:  state_in = S_FINAL;
         S_FLUSH: state_in = S_FINAL;
         S_FINAL: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decode commands
   assign busy        = (state_ff != S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.load    = (state_ff == S_LOAD);
   assign cmd.walk    = (state_ff == S_WALK);
   assign cmd.link    = (state_ff == S_LINK);
   assign cmd.post    = (state_ff == S_POST);
   assign cmd.flush   = (state_ff == S_FLUSH);
   assign cmd.fin     = (state_ff == S_FINAL);

endmodule

// File: design/cspw_dp.sv
// ----------------------------------------------------------------------------
// cspw_dp: semaphore and waiter datapath
// Holds the semaphore store, the waiter pool, the live flags, the
// configuration and the reply register; works one step per command.
// ----------------------------------------------------------------------------
module cspw_dp #(
   parameter int SEM_SLOTS    = 64,
   parameter int WAITER_SLOTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cspw_pkg::cspw_cmd_type  cmd,
   output cspw_pkg::cspw_stat_type stat,
   input  logic [2:0]             req_op,
   input  logic [5:0]             req_sem_index,
   input  logic [15:0]            req_request_id,
   input  logic [15:0]            req_conn_server,
   input  logic [15:0]            req_conn_client,
   input  logic [7:0]             req_priority_req,
   input  logic [30:0]            req_initial_value,
   input  logic                   csr_write_en,
   input  logic                   csr_index,
   input  logic [30:0]            csr_wdata,
   output logic                   rsp_strobe,
   output logic [15:0]            rsp_reply_to,
   output logic [2:0]             rsp_status,
   output logic [30:0]            rsp_value,
   output logic                   rsp_last
);

   localparam int LW   = $clog2(WAITER_SLOTS + 1);
   localparam int WAW  = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
   localparam int SW   = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
   localparam int SEMW = 32 + LW;
   localparam int WDW  = 16 + 32 + 8;
   localparam logic [LW-1:0] QEND = LW'(WAITER_SLOTS);

   // request and walk registers
   logic [2:0]  op_ff, op_in;
   logic [5:0]  idx_ff, idx_in;
   logic        idx_ok_ff, idx_ok_in;
   logic [15:0] tag_ff, tag_in;
   logic [31:0] conn_ff, conn_in;
   logic [7:0]  prio_ff, prio_in;
   logic [30:0] init_ff, init_in;
   logic [31:0] count_ff, count_in;
   logic [LW-1:0] head_ff, head_in, cur_ff, cur_in, prev_ff, prev_in, steps_ff, steps_in;
   logic [WAW-1:0] free_ff, free_in;
   logic        pend_v_ff, pend_v_in;
   logic [15:0] pend_tag_ff, pend_tag_in;
   logic        fin_emit_ff, fin_emit_in;
   logic [15:0] fin_tag_ff, fin_tag_in;
   logic [2:0]  fin_st_ff, fin_st_in;
   logic [30:0] fin_val_ff, fin_val_in;
   logic        lk_ff, lk_in;
   logic [SEM_SLOTS-1:0]    live_ff, live_in;
   logic [WAITER_SLOTS-1:0] wbusy_ff, wbusy_in;
   logic [6:0]  total_ff, total_in;
   logic [30:0] maxv_ff, maxv_in;
   logic [6:0]  maxo_ff, maxo_in;
   logic        rsp_v_ff, rsp_v_in;
   logic [15:0] rsp_tag_ff, rsp_tag_in;
   logic [2:0]  rsp_st_ff, rsp_st_in;
   logic [30:0] rsp_val_ff, rsp_val_in;
   logic        rsp_last_ff, rsp_last_in;

   // memory ports
   logic            sem_we;
   logic [SW-1:0]   sem_ra;
   logic [SEMW-1:0] sem_wd, sem_rd;
   logic            wd_we;
   logic [WDW-1:0]  wd_wd, wd_rd;
   logic            wn_we;
   logic [WAW-1:0]  wn_wa, w_ra;
   logic [LW-1:0]   wn_wd, wn_rd;

   logic [SW-1:0]  sidx;
   logic           live_cur;
   logic [31:0]    ld_count, cnt_inc;
   logic [LW-1:0]  ld_head, steps_nx;
   logic [15:0]    wd_tag;
   logic [31:0]    wd_conn;
   logic [7:0]     wd_prio;
   logic [WAW-1:0] free_w;
   logic           free_ok;
   logic           hit, more;

   cspw_ram #(.WIDTH(SEMW), .DEPTH(SEM_SLOTS)) u_sem_ram (
      .clock   (clock),
      .wr_en   (sem_we),
      .wr_addr (sidx),
      .wr_data (sem_wd),
      .rd_addr (sem_ra),
      .rd_data (sem_rd)
   );

   cspw_ram #(.WIDTH(WDW), .DEPTH(WAITER_SLOTS)) u_wdata_ram (
      .clock   (clock),
      .wr_en   (wd_we),
      .wr_addr (free_ff),
      .wr_data (wd_wd),
      .rd_addr (w_ra),
      .rd_data (wd_rd)
   );

   cspw_ram #(.WIDTH(LW), .DEPTH(WAITER_SLOTS)) u_wnext_ram (
      .clock   (clock),
      .wr_en   (wn_we),
      .wr_addr (wn_wa),
      .wr_data (wn_wd),
      .rd_addr (w_ra),
      .rd_data (wn_rd)
   );

   // find the lowest free waiter entry
   always_comb begin
      free_w  = '0;
      free_ok = 1'b0;
      for (int i = WAITER_SLOTS - 1; i >= 0; i--) begin
         if (!wbusy_ff[i]) begin
            free_w  = WAW'(i);
            free_ok = 1'b1;
         end
      end
   end

   assign sidx     = SW'(idx_ff);
   assign live_cur = idx_ok_ff && live_ff[sidx];
   assign ld_count = sem_rd[SEMW-1:LW];
   assign ld_head  = sem_rd[LW-1:0];
   assign cnt_inc  = ld_count + 32'd1;
   assign wd_tag   = wd_rd[55:40];
   assign wd_conn  = wd_rd[39:8];
   assign wd_prio  = wd_rd[7:0];
   assign steps_nx = steps_ff + LW'(1);
   assign more     = (steps_nx < QEND) && (wn_rd < QEND);
   assign hit      = (op_ff == cspw_pkg::OP_DESTROY) ||
                     ((op_ff == cspw_pkg::OP_CANCEL) && (wd_tag == tag_ff)) ||
                     ((op_ff == cspw_pkg::OP_CLOSE) && (wd_conn == conn_ff));
   assign sem_wd   = {count_ff, head_ff};
   assign wd_wd    = {tag_ff, conn_ff, prio_ff};

   // next values for every step
   always_comb begin
      op_in = op_ff; idx_in = idx_ff; idx_ok_in = idx_ok_ff; tag_in = tag_ff;
      conn_in = conn_ff; prio_in = prio_ff; init_in = init_ff;
      count_in = count_ff; head_in = head_ff; cur_in = cur_ff; prev_in = prev_ff;
      steps_in = steps_ff; free_in = free_ff;
      pend_v_in = pend_v_ff; pend_tag_in = pend_tag_ff;
      fin_emit_in = fin_emit_ff; fin_tag_in = fin_tag_ff; fin_st_in = fin_st_ff;
      fin_val_in = fin_val_ff; lk_in = lk_ff;
      live_in = live_ff; wbusy_in = wbusy_ff; total_in = total_ff;
      maxv_in = maxv_ff; maxo_in = maxo_ff;
      rsp_v_in = 1'b0; rsp_tag_in = rsp_tag_ff; rsp_st_in = rsp_st_ff;
      rsp_val_in = rsp_val_ff; rsp_last_in = rsp_last_ff;
      sem_we = 1'b0; sem_ra = SW'(req_sem_index);
      wd_we = 1'b0; wn_we = 1'b0; wn_wa = free_ff; wn_wd = cur_ff;
      w_ra = cur_ff[WAW-1:0];
      stat.after_load  = cspw_pkg::NXT_FINAL;
      stat.walk_last   = 1'b0;
      stat.walk_insert = (op_ff == cspw_pkg::OP_WAIT);

      // configuration writes
      if (csr_write_en) begin
         if (csr_index == cspw_pkg::CSR_MAX_VALUE) maxv_in = csr_wdata;
         else maxo_in = csr_wdata[6:0];
      end

      // latch the request beat
      if (cmd.capture) begin
         op_in = req_op; idx_in = req_sem_index; tag_in = req_request_id;
         idx_ok_in = (32'(req_sem_index) < SEM_SLOTS);
         conn_in = {req_conn_server, req_conn_client};
         prio_in = req_priority_req; init_in = req_initial_value;
         lk_in = 1'b0; pend_v_in = 1'b0;
      end

      // decide on the loaded semaphore
      if (cmd.load) begin
         count_in = ld_count; head_in = ld_head;
         cur_in = ld_head; prev_in = QEND; steps_in = '0;
         w_ra = ld_head[WAW-1:0];
         fin_emit_in = 1'b1; fin_tag_in = tag_ff; fin_st_in = cspw_pkg::ST_OK;
         fin_val_in = '0;
         if (!idx_ok_ff) begin
            fin_st_in = cspw_pkg::ST_BADH;
         end else if (op_ff == cspw_pkg::OP_CREATE) begin
            if (init_ff > maxv_ff) fin_st_in = cspw_pkg::ST_INVALID;
            else if (live_ff[sidx]) fin_st_in = cspw_pkg::ST_OK;
            else if (total_ff >= maxo_ff) fin_st_in = cspw_pkg::ST_TOOMANY;
            else begin
               live_in[sidx] = 1'b1;
               total_in = total_ff + 7'd1;
               count_in = {1'b0, init_ff};
               head_in  = QEND;
            end
         end else if (!live_cur) begin
            fin_st_in = cspw_pkg::ST_BADH;
         end else begin
            case (op_ff)
               cspw_pkg::OP_WAIT, cspw_pkg::OP_TRYWAIT: begin
                  if ($signed(ld_count) > 32'sd0) begin
                     count_in = ld_count - 32'd1;
                  end else if (op_ff == cspw_pkg::OP_TRYWAIT) begin
                     fin_st_in = cspw_pkg::ST_AGAIN;
                  end else if (!free_ok) begin
                     fin_st_in = cspw_pkg::ST_NOSPACE;
                  end else begin
                     fin_emit_in = 1'b0;
                     count_in = ld_count - 32'd1;
                     free_in = free_w;
                     stat.after_load = (ld_head < QEND) ? cspw_pkg::NXT_WALK
                                                        : cspw_pkg::NXT_LINK;
                  end
               end
               cspw_pkg::OP_POST: begin
                  if ($signed(ld_count) >= $signed({1'b0, maxv_ff})) begin
                     fin_st_in = cspw_pkg::ST_AGAIN;
                  end else begin
                     count_in = cnt_inc;
                     if (!($signed(cnt_inc) > 32'sd0) && (ld_head < QEND))
                        stat.after_load = cspw_pkg::NXT_POST;
                  end
               end
               cspw_pkg::OP_GETVAL: begin
                  if ($signed(ld_count) > 32'sd0) fin_val_in = ld_count[30:0];
               end
               default: begin
                  stat.after_load = (ld_head < QEND) ? cspw_pkg::NXT_WALK
                                                     : cspw_pkg::NXT_FLUSH;
               end
            endcase
         end
      end

      // one queue entry per cycle
      if (cmd.walk) begin
         w_ra = wn_rd[WAW-1:0];
         if (op_ff == cspw_pkg::OP_WAIT) begin
            if (wd_prio >= prio_ff) begin
               prev_in = cur_ff; cur_in = wn_rd; steps_in = steps_nx;
               stat.walk_last = !more;
            end else begin
               stat.walk_last = 1'b1;
            end
         end else begin
            if (hit) begin
               if (pend_v_ff) begin
                  rsp_v_in = 1'b1; rsp_tag_in = pend_tag_ff; rsp_val_in = '0;
                  rsp_st_in = (op_ff == cspw_pkg::OP_CANCEL) ? cspw_pkg::ST_INTR
                                                             : cspw_pkg::ST_BADH;
                  rsp_last_in = 1'b0;
               end
               pend_v_in = 1'b1; pend_tag_in = wd_tag;
               if (prev_ff == QEND) head_in = wn_rd;
               else begin
                  wn_we = 1'b1; wn_wa = prev_ff[WAW-1:0]; wn_wd = wn_rd;
               end
               wbusy_in[cur_ff[WAW-1:0]] = 1'b0;
               count_in = count_ff + 32'd1;
            end else begin
               prev_in = cur_ff;
            end
            cur_in = wn_rd; steps_in = steps_nx;
            stat.walk_last = !more;
         end
      end

      // store the new waiter
      if (cmd.link) begin
         wd_we = 1'b1; wn_we = 1'b1; wn_wa = free_ff; wn_wd = cur_ff;
         wbusy_in[free_ff] = 1'b1;
         if (prev_ff == QEND) head_in = LW'(free_ff);
         else lk_in = 1'b1;
      end

      // hand the unit to the head waiter
      if (cmd.post) begin
         head_in = wn_rd;
         wbusy_in[cur_ff[WAW-1:0]] = 1'b0;
         rsp_v_in = 1'b1; rsp_st_in = cspw_pkg::ST_OK; rsp_val_in = '0;
         rsp_last_in = 1'b0;
         fin_emit_in = 1'b1; fin_st_in = cspw_pkg::ST_OK;
         if (wd_prio > prio_ff) begin
            rsp_tag_in = wd_tag; fin_tag_in = tag_ff;
         end else begin
            rsp_tag_in = tag_ff; fin_tag_in = wd_tag;
         end
      end

      // drain the held release reply, or for cancel make it the closing one, and set up the closing reply
      if (cmd.flush) begin
         fin_emit_in = 1'b1; fin_val_in = '0;
         if (op_ff == cspw_pkg::OP_CANCEL) begin
            fin_tag_in = pend_v_ff ? pend_tag_ff : tag_ff;
            fin_st_in  = pend_v_ff ? cspw_pkg::ST_INTR : cspw_pkg::ST_NOTFOUND;
         end else begin
            fin_tag_in = tag_ff; fin_st_in = cspw_pkg::ST_OK;
            if (pend_v_ff) begin
               rsp_v_in = 1'b1; rsp_tag_in = pend_tag_ff; rsp_st_in = cspw_pkg::ST_BADH;
               rsp_val_in = '0; rsp_last_in = 1'b0;
            end
         end
         if (op_ff == cspw_pkg::OP_DESTROY) begin
            live_in[sidx] = 1'b0;
            head_in = QEND;
            total_in = (total_ff != 7'd0) ? total_ff - 7'd1 : 7'd0;
         end
      end

      // write back and send the final reply
      if (cmd.fin) begin
         sem_we = idx_ok_ff;
         if (lk_ff) begin
            wn_we = 1'b1; wn_wa = prev_ff[WAW-1:0]; wn_wd = LW'(free_ff);
         end
         if (fin_emit_ff) begin
            rsp_v_in = 1'b1; rsp_tag_in = fin_tag_ff; rsp_st_in = fin_st_ff;
            rsp_val_in = fin_val_ff; rsp_last_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         wbusy_ff <= '0;
         total_ff <= '0;
         maxv_ff  <= 31'h7FFF_FFFF;
         maxo_ff  <= 7'd64;
         rsp_v_ff <= 1'b0;
      end else begin
         live_ff  <= live_in;
         wbusy_ff <= wbusy_in;
         total_ff <= total_in;
         maxv_ff  <= maxv_in;
         maxo_ff  <= maxo_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff <= op_in; idx_ff <= idx_in; idx_ok_ff <= idx_ok_in; tag_ff <= tag_in;
      conn_ff <= conn_in; prio_ff <= prio_in; init_ff <= init_in;
      count_ff <= count_in; head_ff <= head_in; cur_ff <= cur_in; prev_ff <= prev_in;
      steps_ff <= steps_in; free_ff <= free_in;
      pend_v_ff <= pend_v_in; pend_tag_ff <= pend_tag_in;
      fin_emit_ff <= fin_emit_in; fin_tag_ff <= fin_tag_in; fin_st_ff <= fin_st_in;
      fin_val_ff <= fin_val_in; lk_ff <= lk_in;
      rsp_tag_ff <= rsp_tag_in; rsp_st_ff <= rsp_st_in;
      rsp_val_ff <= rsp_val_in; rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe   = rsp_v_ff;
   assign rsp_reply_to = rsp_tag_ff;
   assign rsp_status   = rsp_st_ff;
   assign rsp_value    = rsp_val_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: design/cspw_checker.sv
// ----------------------------------------------------------------------------
// cspw_checker: port-level checks
// Relates request acceptance, busy and reply beats over time.
// ----------------------------------------------------------------------------
module cspw_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [30:0] rsp_value,
   input logic        rsp_last
);

   // a reply beat only follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("reply beat without work");

   // an accepted request keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted request not busy");

   // the final beat ends the request
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy) else $error("busy after final beat");

   // earlier beats come while the request is still at work
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy) else $error("idle on a middle beat");

   // only a successful reply carries a count
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != cspw_pkg::ST_OK)) |-> (rsp_value == 31'd0))
      else $error("value on an error reply");

endmodule

bind counting_semaphore_priority_waitq cspw_checker u_cspw_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_value  (rsp_value),
   .rsp_last   (rsp_last)
);
